[sv/i2cm_pkg.sv]
// Shared types, codes and reset values of the I2C register word access master.
`default_nettype none
package i2cm_pkg;

	localparam int ACK_POLLS_DEFAULT = 10;

	localparam int CFG_INDEX_W = 2;
	localparam int CFG_DATA_W  = 16;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_TARGET_ADDRESS    = 2'd0,
		REG_HALF_PERIOD_TICKS = 2'd1,
		REG_RETRY_LIMIT       = 2'd2,
		REG_RETRY_WAIT_TICKS  = 2'd3
	} reg_index_t;

	typedef enum logic [1:0] {
		ACT_TICK  = 2'd0,
		ACT_WRITE = 2'd1,
		ACT_READ  = 2'd2,
		ACT_PROBE = 2'd3
	} action_t;

	localparam logic [1:0] STATUS_OK        = 2'd0;
	localparam logic [1:0] STATUS_ADDR_FAIL = 2'd1;
	localparam logic [1:0] STATUS_DATA_NACK = 2'd2;

	localparam logic [6:0]  TARGET_ADDRESS_RST    = 7'd0;
	localparam logic [7:0]  HALF_PERIOD_TICKS_RST = 8'd30;
	localparam logic [2:0]  RETRY_LIMIT_RST       = 3'd3;
	localparam logic [15:0] RETRY_WAIT_TICKS_RST  = 16'd1000;

	localparam logic [15:0] LOW_BYTE_MASK  = 16'h00FF;
	localparam logic [15:0] HIGH_BYTE_MASK = 16'hFF00;

	typedef struct packed {
		logic [6:0]  target_address;
		logic [7:0]  half_period_ticks;
		logic [2:0]  retry_limit;
		logic [15:0] retry_wait_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  action;
		logic [7:0]  reg_addr;
		logic [15:0] write_data;
		logic        sda_in;
		logic        scl_in;
	} cmd_t;

	typedef struct packed {
		logic        scl_pull_low;
		logic        sda_pull_low;
		logic        busy_res;
		logic        done_res;
		logic [1:0]  status;
		logic [15:0] read_data;
	} res_t;

endpackage
`default_nettype wire

[sv/i2cm_ifs.sv]
// Command and result channel interfaces of the I2C register word access master.
`default_nettype none
interface i2cm_cmd_if;
	logic        valid;
	logic        ready;
	logic [1:0]  action;
	logic [7:0]  reg_addr;
	logic [15:0] write_data;
	logic        sda_in;
	logic        scl_in;

	modport source (output valid, action, reg_addr, write_data, sda_in, scl_in, input ready);
	modport sink (input valid, action, reg_addr, write_data, sda_in, scl_in, output ready);
endinterface

interface i2cm_res_if;
	logic        valid;
	logic        ready;
	logic        scl_pull_low;
	logic        sda_pull_low;
	logic        busy_res;
	logic        done_res;
	logic [1:0]  status;
	logic [15:0] read_data;

	modport source (output valid, scl_pull_low, sda_pull_low, busy_res, done_res, status,
		read_data, input ready);
	modport sink (input valid, scl_pull_low, sda_pull_low, busy_res, done_res, status,
		read_data, output ready);
endinterface
`default_nettype wire

[sv/i2c_master_register_word_access.sv]
// Top level of the I2C register word access master.
`default_nettype none
// Open-drain I2C master for 16-bit register writes, reads and address probes. Every command
// transaction is one bus tick and yields exactly one result transaction with the line drives,
// busy, done, status and last read word. One transaction is taken per clock cycle while the
// result side keeps up. The input register captures a command when it is taken, and the
// sequencer state register, which doubles as the result register, updates from it once the
// result side can advance, so the result is offered from then on. Configuration writes
// belong in idle periods only.
module i2c_master_register_word_access #(
	parameter int ACK_POLLS = i2cm_pkg::ACK_POLLS_DEFAULT
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [i2cm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data,
	i2cm_cmd_if.sink                               cmd,
	i2cm_res_if.source                             res
);

	i2cm_pkg::cfg_t cfg;
	i2cm_pkg::cmd_t cmd_s1;
	i2cm_pkg::res_t res_s2;
	logic           valid_s1;
	logic           valid_s2;
	logic           advance;
	logic           step;

	assign advance   = !valid_s2 || res.ready;
	assign step      = valid_s1 && advance;
	assign cmd.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (cmd.valid && cmd.ready) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
			if (step) begin
				valid_s2 <= 1'b1;
			end else if (res.ready) begin
				valid_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready) begin
			cmd_s1.action     <= cmd.action;
			cmd_s1.reg_addr   <= cmd.reg_addr;
			cmd_s1.write_data <= cmd.write_data;
			cmd_s1.sda_in     <= cmd.sda_in;
			cmd_s1.scl_in     <= cmd.scl_in;
		end
	end

	i2cm_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	i2cm_seq #(
		.ACK_POLLS (ACK_POLLS)
	) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.cmd    (cmd_s1),
		.cfg    (cfg),
		.res    (res_s2)
	);

	assign res.valid        = valid_s2;
	assign res.scl_pull_low = res_s2.scl_pull_low;
	assign res.sda_pull_low = res_s2.sda_pull_low;
	assign res.busy_res     = res_s2.busy_res;
	assign res.done_res     = res_s2.done_res;
	assign res.status       = res_s2.status;
	assign res.read_data    = res_s2.read_data;

	// A finished transaction never reports itself as still busy.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && res_s2.done_res) |-> !res_s2.busy_res)
		else $error("done reported while busy");

	// Status always holds one of the defined codes.
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 |-> ((res_s2.status == i2cm_pkg::STATUS_OK)
			|| (res_s2.status == i2cm_pkg::STATUS_ADDR_FAIL)
			|| (res_s2.status == i2cm_pkg::STATUS_DATA_NACK)))
		else $error("undefined status code");

	// The command side stalls only when both stages are full and the result is stalled.
	assert property (@(posedge clk) disable iff (!arst_n)
		!cmd.ready |-> (valid_s1 && valid_s2 && !res.ready))
		else $error("command side stalled without cause");

	// A stalled result keeps the sequencer frozen.
	assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && !res.ready) |=> $stable(res_s2))
		else $error("sequencer state moved under a stalled result");

endmodule
`default_nettype wire

[sv/i2cm_cfg.sv]
// Configuration register bank of the I2C register word access master.
`default_nettype none
module i2cm_cfg (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire logic                              cfg_we,
	input  wire logic [i2cm_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  wire logic [i2cm_pkg::CFG_DATA_W-1:0]  cfg_data,
	output i2cm_pkg::cfg_t                         cfg
);

	i2cm_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_address    <= i2cm_pkg::TARGET_ADDRESS_RST;
			cfg_q.half_period_ticks <= i2cm_pkg::HALF_PERIOD_TICKS_RST;
			cfg_q.retry_limit       <= i2cm_pkg::RETRY_LIMIT_RST;
			cfg_q.retry_wait_ticks  <= i2cm_pkg::RETRY_WAIT_TICKS_RST;
		end else if (cfg_we) begin
			unique case (i2cm_pkg::reg_index_t'(cfg_index))
				i2cm_pkg::REG_TARGET_ADDRESS:    cfg_q.target_address    <= cfg_data[6:0];
				i2cm_pkg::REG_HALF_PERIOD_TICKS: cfg_q.half_period_ticks <= cfg_data[7:0];
				i2cm_pkg::REG_RETRY_LIMIT:       cfg_q.retry_limit       <= cfg_data[2:0];
				i2cm_pkg::REG_RETRY_WAIT_TICKS:  cfg_q.retry_wait_ticks  <= cfg_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

[sv/i2cm_seq.sv]
// Bus sequencer: advances the I2C transaction state by one tick per step.
`default_nettype none
module i2cm_seq #(
	parameter int ACK_POLLS = i2cm_pkg::ACK_POLLS_DEFAULT
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      step,
	input  wire i2cm_pkg::cmd_t cmd,
	input  wire i2cm_pkg::cfg_t cfg,
	output i2cm_pkg::res_t res
);

	localparam int PW = $clog2(ACK_POLLS + 1);

	typedef enum logic [4:0] {
		PH_IDLE, PH_ST0, PH_ST1, PH_ST2, PH_ST3,
		PH_TX0, PH_TX1, PH_TX2, PH_TX3, PH_ACK, PH_TX4, PH_TX5, PH_TX6,
		PH_RX0, PH_RX1, PH_RX2, PH_RX3, PH_RX4, PH_RX5,
		PH_SP0, PH_SP1, PH_SP2, PH_SP3, PH_RETRY
	} phase_t;

	phase_t      phase_q, phase_n;
	logic [1:0]  op_kind_q, op_kind_n;
	logic [15:0] delay_q, delay_n;
	logic [2:0]  bit_q, bit_n;
	logic [1:0]  byte_q, byte_n;
	logic [7:0]  shift_q, shift_n;
	logic [PW-1:0] polls_q, polls_n;
	logic [2:0]  attempts_q, attempts_n;
	logic [7:0]  reg_q, reg_n;
	logic [15:0] word_q, word_n;
	logic [15:0] rx_q, rx_n;
	logic        addr_stage_q, addr_stage_n;
	logic        dir_read_q, dir_read_n;
	logic        retry_stop_q, retry_stop_n;
	logic        ack_ok_q, ack_ok_n;
	logic        done_q, done_n;
	logic [1:0]  status_q, status_n;
	logic        scl_low_q, scl_low_n;
	logic        sda_low_q, sda_low_n;

	logic [15:0] half_ticks;
	logic [1:0]  byte_inc;

	assign half_ticks = {8'd0, cfg.half_period_ticks};
	assign byte_inc   = byte_q + 2'd1;

	always_comb begin
		phase_n      = phase_q;
		op_kind_n    = op_kind_q;
		delay_n      = delay_q;
		bit_n        = bit_q;
		byte_n       = byte_q;
		shift_n      = shift_q;
		polls_n      = polls_q;
		attempts_n   = attempts_q;
		reg_n        = reg_q;
		word_n       = word_q;
		rx_n         = rx_q;
		addr_stage_n = addr_stage_q;
		dir_read_n   = dir_read_q;
		retry_stop_n = retry_stop_q;
		ack_ok_n     = ack_ok_q;
		done_n       = 1'b0;
		status_n     = status_q;
		scl_low_n    = scl_low_q;
		sda_low_n    = sda_low_q;

		if (delay_q != 16'd0) begin
			delay_n = delay_q - 16'd1;
		end else if (phase_q == PH_IDLE) begin
			if (cmd.action != i2cm_pkg::ACT_TICK) begin
				op_kind_n    = cmd.action;
				reg_n        = cmd.reg_addr;
				word_n       = cmd.write_data;
				byte_n       = 2'd0;
				bit_n        = 3'd0;
				dir_read_n   = 1'b0;
				addr_stage_n = 1'b1;
				if (cfg.retry_limit == 3'd0) begin
					phase_n  = PH_IDLE;
					delay_n  = 16'd0;
					status_n = i2cm_pkg::STATUS_ADDR_FAIL;
					done_n   = 1'b1;
				end else begin
					attempts_n = cfg.retry_limit;
					phase_n    = PH_ST0;
				end
			end
		end else begin
			unique case (phase_q)
				PH_ST0: begin
					attempts_n = attempts_q - 3'd1;
					sda_low_n  = 1'b0;
					delay_n    = half_ticks;
					phase_n    = PH_ST1;
				end
				PH_ST1: begin
					scl_low_n = 1'b0;
					delay_n   = half_ticks;
					phase_n   = PH_ST2;
				end
				PH_ST2: begin
					if (!cmd.sda_in || !cmd.scl_in) begin
						retry_stop_n = 1'b1;
						phase_n      = PH_SP0;
					end else begin
						sda_low_n = 1'b1;
						delay_n   = half_ticks;
						phase_n   = PH_ST3;
					end
				end
				PH_ST3: begin
					scl_low_n = 1'b1;
					delay_n   = half_ticks;
					shift_n   = {cfg.target_address, dir_read_q};
					bit_n     = 3'd0;
					phase_n   = PH_TX0;
				end
				PH_TX0: begin
					sda_low_n = !shift_q[7];
					delay_n   = half_ticks;
					phase_n   = PH_TX1;
				end
				PH_TX1: begin
					scl_low_n = 1'b0;
					shift_n   = {shift_q[6:0], 1'b0};
					delay_n   = half_ticks;
					phase_n   = PH_TX2;
				end
				PH_TX2: begin
					scl_low_n = 1'b1;
					if (bit_q == 3'd7) begin
						bit_n   = 3'd0;
						phase_n = PH_TX3;
					end else begin
						bit_n   = bit_q + 3'd1;
						phase_n = PH_TX0;
					end
				end
				PH_TX3: begin
					sda_low_n = 1'b0;
					delay_n   = half_ticks;
					polls_n   = PW'(ACK_POLLS);
					phase_n   = PH_ACK;
				end
				PH_ACK: begin
					if (!cmd.sda_in) begin
						ack_ok_n = 1'b1;
						phase_n  = PH_TX4;
					end else if (polls_q == '0) begin
						ack_ok_n = 1'b0;
						phase_n  = PH_TX4;
					end else begin
						polls_n = polls_q - PW'(1);
						delay_n = half_ticks;
					end
				end
				PH_TX4: begin
					scl_low_n = 1'b0;
					delay_n   = half_ticks;
					phase_n   = PH_TX5;
				end
				PH_TX5: begin
					scl_low_n = 1'b1;
					delay_n   = half_ticks;
					phase_n   = PH_TX6;
				end
				PH_TX6: begin
					sda_low_n = 1'b1;
					if (addr_stage_q) begin
						if (!ack_ok_q) begin
							retry_stop_n = 1'b1;
							phase_n      = PH_SP0;
						end else begin
							addr_stage_n = 1'b0;
							if (op_kind_q == i2cm_pkg::ACT_PROBE) begin
								retry_stop_n = 1'b0;
								phase_n      = PH_SP0;
							end else if (dir_read_q) begin
								byte_n  = 2'd0;
								bit_n   = 3'd0;
								shift_n = 8'd0;
								phase_n = PH_RX0;
							end else begin
								byte_n  = 2'd0;
								shift_n = reg_q;
								bit_n   = 3'd0;
								phase_n = PH_TX0;
							end
						end
					end else if (!ack_ok_q) begin
						phase_n  = PH_IDLE;
						delay_n  = 16'd0;
						status_n = i2cm_pkg::STATUS_DATA_NACK;
						done_n   = 1'b1;
					end else begin
						byte_n = byte_inc;
						if (op_kind_q == i2cm_pkg::ACT_READ) begin
							dir_read_n   = 1'b1;
							addr_stage_n = 1'b1;
							if (cfg.retry_limit == 3'd0) begin
								phase_n  = PH_IDLE;
								delay_n  = 16'd0;
								status_n = i2cm_pkg::STATUS_ADDR_FAIL;
								done_n   = 1'b1;
							end else begin
								attempts_n = cfg.retry_limit;
								phase_n    = PH_ST0;
							end
						end else if (byte_inc == 2'd1) begin
							shift_n = word_q[7:0] & i2cm_pkg::LOW_BYTE_MASK[7:0];
							bit_n   = 3'd0;
							phase_n = PH_TX0;
						end else if (byte_inc == 2'd2) begin
							shift_n = 8'((word_q & i2cm_pkg::HIGH_BYTE_MASK) >> 8);
							bit_n   = 3'd0;
							phase_n = PH_TX0;
						end else begin
							retry_stop_n = 1'b0;
							phase_n      = PH_SP0;
						end
					end
				end
				PH_RX0: begin
					sda_low_n = 1'b0;
					delay_n   = half_ticks;
					phase_n   = PH_RX1;
				end
				PH_RX1: begin
					scl_low_n = 1'b0;
					delay_n   = half_ticks;
					phase_n   = PH_RX2;
				end
				PH_RX2: begin
					shift_n   = {shift_q[6:0], cmd.sda_in};
					scl_low_n = 1'b1;
					delay_n   = half_ticks;
					if (bit_q == 3'd7) begin
						bit_n   = 3'd0;
						phase_n = PH_RX3;
					end else begin
						bit_n   = bit_q + 3'd1;
						phase_n = PH_RX0;
					end
				end
				PH_RX3: begin
					sda_low_n = (byte_q == 2'd0);
					delay_n   = half_ticks;
					phase_n   = PH_RX4;
				end
				PH_RX4: begin
					scl_low_n = 1'b0;
					delay_n   = half_ticks;
					phase_n   = PH_RX5;
				end
				PH_RX5: begin
					scl_low_n = 1'b1;
					if (byte_q == 2'd0) begin
						word_n  = {8'd0, shift_q};
						byte_n  = 2'd1;
						bit_n   = 3'd0;
						shift_n = 8'd0;
						phase_n = PH_RX0;
					end else begin
						rx_n         = {shift_q, word_q[7:0]};
						retry_stop_n = 1'b0;
						phase_n      = PH_SP0;
					end
				end
				PH_SP0: begin
					scl_low_n = 1'b1;
					delay_n   = half_ticks;
					phase_n   = PH_SP1;
				end
				PH_SP1: begin
					sda_low_n = 1'b1;
					delay_n   = half_ticks;
					phase_n   = PH_SP2;
				end
				PH_SP2: begin
					scl_low_n = 1'b0;
					delay_n   = half_ticks;
					phase_n   = PH_SP3;
				end
				PH_SP3: begin
					sda_low_n = 1'b0;
					if (retry_stop_q) begin
						delay_n = cfg.retry_wait_ticks;
						phase_n = PH_RETRY;
					end else begin
						phase_n  = PH_IDLE;
						delay_n  = 16'd0;
						status_n = i2cm_pkg::STATUS_OK;
						done_n   = 1'b1;
					end
				end
				PH_RETRY: begin
					if (attempts_q == 3'd0) begin
						phase_n  = PH_IDLE;
						delay_n  = 16'd0;
						status_n = i2cm_pkg::STATUS_ADDR_FAIL;
						done_n   = 1'b1;
					end else begin
						phase_n = PH_ST0;
					end
				end
				default: phase_n = PH_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_IDLE;
			op_kind_q    <= 2'd0;
			delay_q      <= 16'd0;
			bit_q        <= 3'd0;
			byte_q       <= 2'd0;
			shift_q      <= 8'd0;
			polls_q      <= '0;
			attempts_q   <= 3'd0;
			reg_q        <= 8'd0;
			word_q       <= 16'd0;
			rx_q         <= 16'd0;
			addr_stage_q <= 1'b0;
			dir_read_q   <= 1'b0;
			retry_stop_q <= 1'b0;
			ack_ok_q     <= 1'b0;
			done_q       <= 1'b0;
			status_q     <= i2cm_pkg::STATUS_OK;
			scl_low_q    <= 1'b0;
			sda_low_q    <= 1'b0;
		end else if (step) begin
			phase_q      <= phase_n;
			op_kind_q    <= op_kind_n;
			delay_q      <= delay_n;
			bit_q        <= bit_n;
			byte_q       <= byte_n;
			shift_q      <= shift_n;
			polls_q      <= polls_n;
			attempts_q   <= attempts_n;
			reg_q        <= reg_n;
			word_q       <= word_n;
			rx_q         <= rx_n;
			addr_stage_q <= addr_stage_n;
			dir_read_q   <= dir_read_n;
			retry_stop_q <= retry_stop_n;
			ack_ok_q     <= ack_ok_n;
			done_q       <= done_n;
			status_q     <= status_n;
			scl_low_q    <= scl_low_n;
			sda_low_q    <= sda_low_n;
		end
	end

	assign res.scl_pull_low = scl_low_q;
	assign res.sda_pull_low = sda_low_q;
	assign res.busy_res     = (phase_q != PH_IDLE);
	assign res.done_res     = done_q;
	assign res.status       = status_q;
	assign res.read_data    = rx_q;

endmodule
`default_nettype wire
